// ----- hdl/polyphonic_sine_adsr_voice_engine_defines.svh -----
// assertion helpers for the voice engine checker
`ifndef POLYPHONIC_SINE_ADSR_VOICE_ENGINE_DEFINES_SVH
`define POLYPHONIC_SINE_ADSR_VOICE_ENGINE_DEFINES_SVH

// clocked check, quiet while reset is held
`define PSAV_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("check failed");

// same with a caller message
`define PSAV_CHECK_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

// ----- hdl/psav_pkg.sv -----
package psav_pkg;

	localparam int VOICE_COUNT      = 5;
	localparam int SAMPLE_RATE_HZ   = 48000;
	localparam int SINE_TABLE_DEPTH = 1024;

	localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int SINE_IW = $clog2(SINE_TABLE_DEPTH);

	// envelope divider: numerator, divisor, quotient
	localparam int DIV_NUM_W = 36;
	localparam int DIV_DEN_W = 20;
	localparam int DIV_Q_W   = 16;

	// mixer widths
	localparam int P1_W  = 34;
	localparam int P2_W  = P1_W + 17;
	localparam int G_W   = P2_W - 12;
	localparam int PAN_W = G_W + 17;
	localparam int SUM_W = PAN_W + VOICE_W;
	localparam int RND_W = SUM_W - 23;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_NOTE_ON  = 2'd1,
		OP_NOTE_OFF = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ENV_ATTACK  = 2'd0,
		ENV_DECAY   = 2'd1,
		ENV_SUSTAIN = 2'd2,
		ENV_RELEASE = 2'd3
	} env_stage_t;

	localparam logic [2:0] REG_GAIN      = 3'd0;
	localparam logic [2:0] REG_PAN_LEFT  = 3'd1;
	localparam logic [2:0] REG_PAN_RIGHT = 3'd2;
	localparam logic [2:0] REG_PEAK      = 3'd3;
	localparam logic [2:0] REG_SUSTAIN   = 3'd4;
	localparam logic [2:0] REG_ATTACK    = 3'd5;
	localparam logic [2:0] REG_DECAY     = 3'd6;
	localparam logic [2:0] REG_RELEASE   = 3'd7;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] key;
		logic [6:0] velocity;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] left_sample;
		logic signed [23:0] right_sample;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_VSEL,
		ST_VREAD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ENV,
		ST_MUL,
		ST_PAN,
		ST_ACC,
		ST_FIN
	} ctrl_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_EVENT,
		CMD_CLEAR,
		CMD_NEXT,
		CMD_READ,
		CMD_DIV,
		CMD_ENV,
		CMD_MUL,
		CMD_PAN,
		CMD_ACC,
		CMD_OUT
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
		logic    take;
	} dp_ctl_t;

	typedef struct packed {
		logic [1:0] op;
		logic       cur_active;
		logic       last_voice;
		logic       use_div;
		logic       div_busy;
		logic       out_full;
	} dp_stat_t;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// keys 116..127, Q16.16 Hz
	localparam longint unsigned TOP_OCTAVE [0:11] = '{
		64'd435478539, 64'd461373440, 64'd488808132, 64'd517874176,
		64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
		64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013
	};

	typedef logic [15:0] sine_rom_t [0:SINE_TABLE_DEPTH];
	typedef logic [31:0] step_tab_t [0:127];

	// quarter-wave sine, Q1.15, taylor series to x^13
	function automatic sine_rom_t build_sine();
		sine_rom_t       t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          q;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if ((n % 2) == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			q = (sum + 64'sd16384) >>> 15;
			if (q > 32767)
				q = 32767;
			t[i] = 16'(q);
		end
		return t;
	endfunction

	// phase increment per key, rounded
	function automatic step_tab_t build_steps();
		step_tab_t       t;
		int              d;
		int              oct;
		longint unsigned num;
		for (int k = 0; k < 128; k++) begin
			d = 127 - k;
			oct = d / 12;
			num = (TOP_OCTAVE[11 - (d % 12)] << 16) >> oct;
			t[k] = 32'((num + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ);
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();
	localparam step_tab_t STEP_TAB = build_steps();

endpackage

// ----- hdl/polyphonic_sine_adsr_voice_engine.sv -----
// Polyphonic sine voice engine with a linear attack/decay/sustain/release envelope per voice.
// Each input word is a sample tick, a note-on or a note-off; only a tick yields an output
// word, a saturated signed 24-bit stereo sample. A tick walks the voices in turn; a sounding
// voice takes longer while its envelope sits on a ramp, because every ramp level goes through
// one shared radix-2 divider that delivers a 16-bit quotient one bit a cycle. Voices are
// served one at a time by a single multiply/accumulate path. Envelope settings are read live
// from the register port, so write them only while the engine is idle. The output register
// lets a finished sample wait while the next word is accepted; a later tick holds in its last
// step until that slot frees.
module polyphonic_sine_adsr_voice_engine
	import psav_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_wdata
);

	// command from sequencer, status back from datapath
	dp_ctl_t  ctl;
	dp_stat_t stat;

	// sequencer: dispatch, per-voice walk, divider wait, output handoff
	psav_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ctl      (ctl),
		.stat     (stat)
	);

	// voice state, envelope math, mixer and config registers
	psav_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hdl/psav_div.sv -----
module psav_div
	import psav_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 busy,
	output logic [DIV_Q_W-1:0]   quo
);

	localparam int CNT_W = $clog2(DIV_Q_W + 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   sh_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// numerator high part is already below the divisor, so only quotient bits iterate
	assign trial = {rem_q, sh_q[DIV_Q_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_Q_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DIV_NUM_W-1:DIV_Q_W];
			sh_q  <= num[DIV_Q_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
			sh_q  <= {sh_q[DIV_Q_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = sh_q;

endmodule

// ----- hdl/psav_dp.sv -----
module psav_dp
	import psav_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_data,
	input  dp_ctl_t     ctl,
	output dp_stat_t    stat,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	in_item_t item_q;

	logic [15:0] gain_q, pan_l_q, pan_r_q, peak_q, sus_q;
	logic [19:0] att_q, dec_q, rel_q;

	logic        act_q   [VOICE_COUNT];
	logic [6:0]  key_q   [VOICE_COUNT];
	logic [31:0] phase_q [VOICE_COUNT];
	env_stage_t  stage_q [VOICE_COUNT];
	logic [20:0] cnt_q   [VOICE_COUNT];
	logic [15:0] lvl_q   [VOICE_COUNT];
	logic [15:0] rst_q   [VOICE_COUNT];

	logic [VOICE_W-1:0] vi_q;

	// note event lookup
	logic               hit;
	logic [VOICE_W-1:0] hit_idx;
	logic               spare;
	logic [VOICE_W-1:0] spare_idx;
	logic               ev_on, ev_off;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		spare = 1'b0;
		spare_idx = '0;
		for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
			if (act_q[v] && key_q[v] == item_q.key) begin
				hit = 1'b1;
				hit_idx = VOICE_W'(v);
			end
			if (!act_q[v]) begin
				spare = 1'b1;
				spare_idx = VOICE_W'(v);
			end
		end
	end

	assign ev_on  = ctl.cmd == CMD_EVENT && item_q.op == OP_NOTE_ON && item_q.velocity != '0;
	assign ev_off = ctl.cmd == CMD_EVENT && item_q.op == OP_NOTE_OFF;

	// envelope plan for the selected voice
	logic [20:0]          c;
	env_stage_t           st, nst;
	logic [20:0]          ncnt;
	logic [15:0]          base;
	logic                 neg, use_div, free_v;
	logic [19:0]          mul_a;
	logic [15:0]          mul_b;
	logic [DIV_DEN_W-1:0] den;

	always_comb begin
		c = cnt_q[vi_q];
		st = stage_q[vi_q];
		nst = st;
		ncnt = c;
		base = '0;
		neg = 1'b0;
		use_div = 1'b0;
		free_v = 1'b0;
		mul_a = '0;
		mul_b = '0;
		den = att_q;
		case (st)
			ENV_ATTACK: begin
				if (c > {1'b0, att_q}) begin
					nst = ENV_DECAY;
					ncnt = '0;
					base = peak_q;
				end else if (att_q == '0) begin
					base = peak_q;
				end else begin
					use_div = 1'b1;
					mul_a = c[19:0];
					mul_b = peak_q;
				end
			end
			ENV_DECAY: begin
				den = dec_q;
				base = (c > {1'b0, dec_q} || dec_q == '0) ? sus_q : peak_q;
				if (c > {1'b0, dec_q}) begin
					nst = ENV_SUSTAIN;
					ncnt = '0;
				end else if (dec_q != '0) begin
					use_div = 1'b1;
					neg = sus_q < peak_q;
					mul_a = c[19:0];
					mul_b = (sus_q < peak_q) ? peak_q - sus_q : sus_q - peak_q;
				end
			end
			ENV_RELEASE: begin
				den = rel_q;
				if (c > {1'b0, rel_q}) begin
					free_v = 1'b1;
				end else if (rel_q != '0) begin
					use_div = 1'b1;
					mul_a = rel_q - c[19:0];
					mul_b = rst_q[vi_q];
				end
			end
			default: begin
				base = sus_q;
			end
		endcase
	end

	// plan and sine read registers
	env_stage_t           nst_s1;
	logic [20:0]          ncnt_s1;
	logic [15:0]          base_s1;
	logic                 neg_s1, use_div_s1, free_s1;
	logic [DIV_NUM_W-1:0] num_s1;
	logic [DIV_DEN_W-1:0] den_s1;
	logic [15:0]          rom_s1;
	logic [1:0]           quad_s1;
	logic [SINE_IW:0]     rom_addr;
	logic [31:0]          ph;

	assign ph = phase_q[vi_q];

	always_comb begin
		if (ph[30])
			rom_addr = (SINE_IW + 1)'(SINE_TABLE_DEPTH) - {1'b0, ph[29 -: SINE_IW]};
		else
			rom_addr = {1'b0, ph[29 -: SINE_IW]};
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == CMD_READ) begin
			nst_s1     <= nst;
			ncnt_s1    <= ncnt;
			base_s1    <= base;
			neg_s1     <= neg;
			use_div_s1 <= use_div;
			free_s1    <= free_v;
			num_s1     <= mul_a * mul_b;
			den_s1     <= den;
			rom_s1     <= SINE_ROM[rom_addr];
			quad_s1    <= ph[31:30];
		end
	end

	logic               div_busy;
	logic [DIV_Q_W-1:0] quo;

	psav_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.cmd == CMD_DIV),
		.num    (num_s1),
		.den    (den_s1),
		.busy   (div_busy),
		.quo    (quo)
	);

	// new level, then sine times level
	logic [15:0]        qsel, lvl_new;
	logic signed [16:0] sv, s;

	assign qsel    = use_div_s1 ? quo : '0;
	assign lvl_new = neg_s1 ? base_s1 - qsel : base_s1 + qsel;
	assign sv      = $signed({1'b0, rom_s1});
	assign s       = quad_s1[1] ? -sv : sv;

	logic signed [P1_W-1:0]  prod1_s2;
	logic signed [P2_W-1:0]  prod2_s3;
	logic signed [P2_W-1:0]  prod2_rnd;
	logic signed [G_W-1:0]   g;
	logic signed [PAN_W-1:0] pl_s4, pr_s4;
	logic signed [SUM_W-1:0] sum_l_q, sum_r_q;

	assign prod2_rnd = prod2_s3 + P2_W'(2048);
	assign g         = prod2_rnd[P2_W-1:12];

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_ENV:   prod1_s2 <= s * $signed({1'b0, lvl_new});
			CMD_MUL:   prod2_s3 <= prod1_s2 * $signed({1'b0, gain_q});
			CMD_PAN: begin
				pl_s4 <= g * $signed({1'b0, pan_l_q});
				pr_s4 <= g * $signed({1'b0, pan_r_q});
			end
			CMD_CLEAR: begin
				sum_l_q <= '0;
				sum_r_q <= '0;
			end
			CMD_ACC: begin
				sum_l_q <= sum_l_q + SUM_W'(pl_s4);
				sum_r_q <= sum_r_q + SUM_W'(pr_s4);
			end
			default: ;
		endcase
	end

	// voice state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				act_q[v]   <= 1'b0;
				key_q[v]   <= '0;
				phase_q[v] <= '0;
			end
			vi_q <= '0;
		end else begin
			if (ev_on && !hit && spare) begin
				act_q[spare_idx] <= 1'b1;
				key_q[spare_idx] <= item_q.key;
			end
			if (ctl.cmd == CMD_READ)
				phase_q[vi_q] <= ph + STEP_TAB[key_q[vi_q]];
			if (ctl.cmd == CMD_ENV && free_s1)
				act_q[vi_q] <= 1'b0;
			case (ctl.cmd)
				CMD_CLEAR:        vi_q <= '0;
				CMD_NEXT, CMD_ACC: vi_q <= vi_q + 1'b1;
				default: ;
			endcase
		end
	end

	// envelope state, always written by a note-on before use
	always_ff @(posedge clk) begin
		if (ev_on && hit) begin
			if (stage_q[hit_idx] == ENV_RELEASE) begin
				stage_q[hit_idx] <= ENV_ATTACK;
				cnt_q[hit_idx]   <= '0;
				rst_q[hit_idx]   <= lvl_q[hit_idx];
			end
		end else if (ev_on && spare) begin
			stage_q[spare_idx] <= ENV_ATTACK;
			cnt_q[spare_idx]   <= '0;
			lvl_q[spare_idx]   <= '0;
			rst_q[spare_idx]   <= '0;
		end
		if (ev_off && hit) begin
			stage_q[hit_idx] <= ENV_RELEASE;
			cnt_q[hit_idx]   <= '0;
			rst_q[hit_idx]   <= lvl_q[hit_idx];
		end
		if (ctl.cmd == CMD_ENV) begin
			stage_q[vi_q] <= nst_s1;
			cnt_q[vi_q]   <= (nst_s1 == ENV_SUSTAIN) ? ncnt_s1 : ncnt_s1 + 1'b1;
			lvl_q[vi_q]   <= lvl_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take)
			item_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 16'd4096;
			pan_l_q <= 16'd23170;
			pan_r_q <= 16'd23170;
			peak_q  <= 16'd65535;
			sus_q   <= 16'd49152;
			att_q   <= 20'd480;
			dec_q   <= 20'd4800;
			rel_q   <= 20'd9600;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:      gain_q  <= cfg_wdata[15:0];
				REG_PAN_LEFT:  pan_l_q <= cfg_wdata[15:0];
				REG_PAN_RIGHT: pan_r_q <= cfg_wdata[15:0];
				REG_PEAK:      peak_q  <= cfg_wdata[15:0];
				REG_SUSTAIN:   sus_q   <= cfg_wdata[15:0];
				REG_ATTACK:    att_q   <= cfg_wdata;
				REG_DECAY:     dec_q   <= cfg_wdata;
				REG_RELEASE:   rel_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// round, saturate, output register
	logic signed [SUM_W-1:0] sl_rnd, sr_rnd;
	logic signed [RND_W-1:0] rl, rr;
	logic signed [23:0]      satl, satr;
	logic                    out_valid_q;

	assign sl_rnd = sum_l_q + SUM_W'(1 << 22);
	assign sr_rnd = sum_r_q + SUM_W'(1 << 22);
	assign rl     = sl_rnd[SUM_W-1:23];
	assign rr     = sr_rnd[SUM_W-1:23];

	always_comb begin
		if (rl > RND_W'(8388607))
			satl = 24'sd8388607;
		else if (rl < -RND_W'(8388608))
			satl = -24'sd8388608;
		else
			satl = rl[23:0];
		if (rr > RND_W'(8388607))
			satr = 24'sd8388607;
		else if (rr < -RND_W'(8388608))
			satr = -24'sd8388608;
		else
			satr = rr[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.cmd == CMD_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == CMD_OUT) begin
			out_data.left_sample  <= satl;
			out_data.right_sample <= satr;
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.op         = item_q.op;
	assign stat.cur_active = act_q[vi_q];
	assign stat.last_voice = vi_q == VOICE_W'(VOICE_COUNT - 1);
	assign stat.use_div    = use_div_s1;
	assign stat.div_busy   = div_busy;
	assign stat.out_full   = out_valid_q & ~out_ready;

endmodule

// ----- hdl/psav_ctrl.sv -----
module psav_ctrl
	import psav_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output dp_ctl_t  ctl,
	input  dp_stat_t stat
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		ctl.cmd  = CMD_NONE;
		in_ready = 1'b0;
		ctl.take = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.take = in_valid;
				if (in_valid)
					state_d = ST_DISP;
			end
			ST_DISP: begin
				case (stat.op)
					OP_TICK: begin
						ctl.cmd = CMD_CLEAR;
						state_d = ST_VSEL;
					end
					OP_NOTE_ON, OP_NOTE_OFF: begin
						ctl.cmd = CMD_EVENT;
						state_d = ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_VSEL: begin
				if (stat.cur_active) begin
					state_d = ST_VREAD;
				end else if (stat.last_voice) begin
					state_d = ST_FIN;
				end else begin
					ctl.cmd = CMD_NEXT;
				end
			end
			ST_VREAD: begin
				ctl.cmd = CMD_READ;
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				if (stat.use_div) begin
					ctl.cmd = CMD_DIV;
					state_d = ST_DIV_WAIT;
				end else begin
					state_d = ST_ENV;
				end
			end
			ST_DIV_WAIT: begin
				if (!stat.div_busy)
					state_d = ST_ENV;
			end
			ST_ENV: begin
				ctl.cmd = CMD_ENV;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				ctl.cmd = CMD_MUL;
				state_d = ST_PAN;
			end
			ST_PAN: begin
				ctl.cmd = CMD_PAN;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				ctl.cmd = CMD_ACC;
				state_d = stat.last_voice ? ST_FIN : ST_VSEL;
			end
			ST_FIN: begin
				if (!stat.out_full) begin
					ctl.cmd = CMD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/psav_checker.sv -----
`include "polyphonic_sine_adsr_voice_engine_defines.svh"

module psav_checker
	import psav_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input in_item_t    in_data,
	input logic        out_valid,
	input logic        out_ready,
	input out_item_t   out_data,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic [19:0] cfg_wdata
);

	// a stalled output word holds
	`PSAV_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

	// note events never make a sample
	`PSAV_CHECK_MSG(a_event_no_out, in_valid && in_ready && in_data.op != OP_TICK |=> !$rose(out_valid), "output after note event")

	// a tick keeps the engine busy
	`PSAV_CHECK_MSG(a_tick_busy, in_valid && in_ready && in_data.op == OP_TICK |=> !in_ready, "ready during tick")

	// a new sample only comes at the end of tick work
	`PSAV_CHECK(a_out_after_work, $rose(out_valid) |-> !$past(in_ready))

	// register writes land only while idle, with known index and data
	`PSAV_CHECK_MSG(a_cfg_idle, cfg_we |-> in_ready && !$isunknown({cfg_index, cfg_wdata}), "config write while busy")

endmodule

bind polyphonic_sine_adsr_voice_engine psav_checker u_chk (.*);
